### rtl/core/sha256_pkg.sv
// Shared types, constants and the rotate function for the SHA-256 message digest.
// No dependencies.
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 61;
    localparam int BLOCK_BYTES         = 64;
    localparam int LENGTH_BYTES        = 8;
    localparam logic [7:0] PAD_BYTE    = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take_byte;     // store input byte, bump counts
        logic load;          // load schedule and working words
        logic round;         // run one round
        logic update;        // add working words into hash
        logic pad_fill;      // write one padding byte
        logic restart;       // reset hash and counts
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic block_full;    // buffer holds 63 bytes, next byte fills it
        logic round_done;    // round 63 under way
        logic pad_last;      // writing final byte of padding
        logic pad_needs_extra;
    } dp_stat_t;

    localparam logic [31:0] ROUND_KEYS [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INITIAL_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

### rtl/core/sha256_message_digest.sv
// Top level of the SHA-256 message digest: controller plus datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_datapath.
`timescale 1ns / 1ps

// Byte-serial SHA-256. Each item carries an optional byte and an optional end
// mark. The 64th byte of a block stalls the input through the load, 64 rounds
// of one round per cycle and the hash update. An end mark walks the padding
// one byte a cycle up to the block end, compresses one or two blocks, then
// presents eight digest words, word 0 first, one per cycle while not stalled.
// The message counter wraps at 2^COUNT_WIDTH bytes.
module sha256_message_digest
#(
    parameter int COUNT_WIDTH = sha256_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  message_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        digest_last
);

    sha256_pkg::dp_cmd_t  cmd;
    sha256_pkg::dp_stat_t stat;
    logic [2:0]           idx;

    sha256_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_present (byte_present),
        .in_end     (message_end),
        .out_stall  (out_stall),
        .stat       (stat),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .out_index  (idx),
        .cmd        (cmd)
    );

    sha256_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_byte   (message_byte),
        .out_index (idx),
        .stat      (stat),
        .out_word  (digest_word)
    );

    assign word_number = idx;
    assign digest_last = (idx == 3'd7);

    // no input taken while a digest is on show
    a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open during digest output");

    // digest word index advances by one on each taken word
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !digest_last) |=> (out_valid && word_number == $past(word_number) + 3'd1))
        else $error("digest word order broken");

    // commands are exclusive
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.take_byte, cmd.load, cmd.round, cmd.update, cmd.pad_fill}))
        else $error("conflicting datapath commands");

endmodule

### rtl/core/sha256_ctrl.sv
// Controller state machine for the SHA-256 message digest.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_present,
    input  logic                  in_end,
    input  logic                  out_stall,
    input  sha256_pkg::dp_stat_t  stat,
    output logic                  in_stall,
    output logic                  out_valid,
    output logic [2:0]            out_index,
    output sha256_pkg::dp_cmd_t   cmd
);

    sha256_pkg::ctrl_state_t state_reg, state_next;
    logic       end_pend_reg, end_pend_next;   // message closes after this block
    logic       final_reg, final_next;         // block in flight is the last one
    logic [2:0] idx_reg, idx_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha256_pkg::ST_IDLE;
            end_pend_reg <= 1'b0;
            final_reg    <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            end_pend_reg <= end_pend_next;
            final_reg    <= final_next;
            idx_reg      <= idx_next;
        end
    end

    wire accept = in_valid && (state_reg == sha256_pkg::ST_IDLE);
    wire fills  = accept && in_present && stat.block_full;

    // next state
    always_comb
    begin
        state_next    = state_reg;
        end_pend_next = end_pend_reg;
        final_next    = final_reg;
        idx_next      = idx_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (fills)
                    begin
                        state_next    = sha256_pkg::ST_LOAD;
                        end_pend_next = in_end;
                        final_next    = 1'b0;
                    end
                    else if (in_end)
                        state_next = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_LOAD:
                state_next = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_ROUND:
                if (stat.round_done)
                    state_next = sha256_pkg::ST_UPDATE;
            sha256_pkg::ST_UPDATE:
            begin
                if (final_reg)
                begin
                    state_next = sha256_pkg::ST_OUT;
                    idx_next   = '0;
                end
                else if (end_pend_reg)
                    state_next = sha256_pkg::ST_PAD;
                else
                    state_next = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_PAD:
            begin
                end_pend_next = 1'b0;
                if (stat.pad_last)
                begin
                    state_next = sha256_pkg::ST_LOAD;
                    final_next = !stat.pad_needs_extra;
                    end_pend_next = stat.pad_needs_extra;
                end
            end
            sha256_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = sha256_pkg::ST_IDLE;
                        final_next = 1'b0;
                    end
                end
            end
            default:
                state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        cmd.take_byte = accept && in_present;
        cmd.load      = (state_reg == sha256_pkg::ST_LOAD);
        cmd.round     = (state_reg == sha256_pkg::ST_ROUND);
        cmd.update    = (state_reg == sha256_pkg::ST_UPDATE);
        cmd.pad_fill  = (state_reg == sha256_pkg::ST_PAD);
        cmd.restart   = (state_reg == sha256_pkg::ST_OUT) && !out_stall && (idx_reg == 3'd7);
        in_stall      = (state_reg != sha256_pkg::ST_IDLE);
        out_valid     = (state_reg == sha256_pkg::ST_OUT);
        out_index     = idx_reg;
    end

endmodule

### rtl/core/sha256_datapath.sv
// Datapath of the SHA-256 message digest: message words, schedule, rounds, hash.
// Depends on sha256_pkg.
`timescale 1ns / 1ps

module sha256_datapath
#(
    parameter int COUNT_WIDTH = sha256_pkg::COUNT_WIDTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha256_pkg::dp_cmd_t  cmd,
    input  logic [7:0]           in_byte,
    input  logic [2:0]           out_index,
    output sha256_pkg::dp_stat_t stat,
    output logic [31:0]          out_word
);

    logic [31:0]            w_reg [16];
    logic [31:0]            v_reg [8];
    logic [31:0]            h_reg [8];
    logic [5:0]             pos_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [5:0]             rnd_reg;
    logic                   pad_first_reg;

    // length field, message bits as 64-bit big endian
    logic [63:0] bits;
    assign bits = 64'({cnt_reg, 3'b000});

    // padding byte at the current write position
    logic [7:0] pad_byte;
    always_comb
    begin
        if (pad_first_reg)
            pad_byte = sha256_pkg::PAD_BYTE;
        else if (pos_reg >= 6'(sha256_pkg::BLOCK_BYTES - sha256_pkg::LENGTH_BYTES)
                 && !stat.pad_needs_extra)
            pad_byte = bits[{~pos_reg[2:0], 3'b000} +: 8];
        else
            pad_byte = 8'h00;
    end

    logic extra_reg;
    assign stat.block_full      = (pos_reg == 6'd63);
    assign stat.round_done      = (rnd_reg == 6'd63);
    assign stat.pad_last        = cmd.pad_fill && (pos_reg == 6'd63);
    // 0x80 landed past byte 55: an extra block is needed
    assign stat.pad_needs_extra = pad_first_reg
                                ? (pos_reg > 6'd55) : extra_reg;

    // schedule word and round terms for this round
    logic [31:0] a15, a2, wv, s0, s1, big0, big1, ch, maj, t1, t2;
    always_comb
    begin
        a15  = w_reg[4'(rnd_reg + 6'd1)];
        a2   = w_reg[4'(rnd_reg + 6'd14)];
        s0   = sha256_pkg::rotr(a15, 7) ^ sha256_pkg::rotr(a15, 18) ^ (a15 >> 3);
        s1   = sha256_pkg::rotr(a2, 17) ^ sha256_pkg::rotr(a2, 19) ^ (a2 >> 10);
        if (rnd_reg < 6'd16)
            wv = w_reg[rnd_reg[3:0]];
        else
            wv = w_reg[rnd_reg[3:0]] + s0 + w_reg[4'(rnd_reg + 6'd9)] + s1;
        big1 = sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
             ^ sha256_pkg::rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + sha256_pkg::ROUND_KEYS[rnd_reg] + wv;
        big0 = sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
             ^ sha256_pkg::rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = big0 + maj;
    end

    // control counters and hash words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cnt_reg       <= '0;
            rnd_reg       <= '0;
            pad_first_reg <= 1'b1;
            extra_reg     <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha256_pkg::INITIAL_HASH[i];
        end
        else
        begin
            if (cmd.take_byte)
            begin
                pos_reg <= pos_reg + 6'd1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.pad_fill)
            begin
                pos_reg       <= pos_reg + 6'd1;
                pad_first_reg <= 1'b0;
                if (pos_reg == 6'd63)
                    extra_reg <= 1'b0;
                else if (pad_first_reg)
                    extra_reg <= (pos_reg > 6'd55);
            end
            if (cmd.load)
                rnd_reg <= '0;
            if (cmd.round)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.update)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            if (cmd.restart)
            begin
                pos_reg       <= '0;
                cnt_reg       <= '0;
                pad_first_reg <= 1'b1;
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= sha256_pkg::INITIAL_HASH[i];
            end
        end
    end

    // message words, schedule and working words
    // bytes land straight in their schedule word lane; every byte of a block is
    // written before the block is loaded
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
            w_reg[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] <= in_byte;
        if (cmd.pad_fill)
            w_reg[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] <= pad_byte;
        if (cmd.load)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        if (cmd.round)
        begin
            w_reg[rnd_reg[3:0]] <= wv;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign out_word = h_reg[out_index];

endmodule

### test/sha256_message_digest_tb.sv
// Self-checking testbench for the byte-serial SHA-256 message digest.
// Depends on sha256_pkg and the sha256_message_digest RTL.
`timescale 1ns / 1ps

// Holds the digest words still to arrive and predicts them from the message bytes.
class digest_scoreboard;
    logic [31:0] hash_acc [8];
    logic [7:0]  block_bytes [64];
    int unsigned fill_count;
    logic [60:0] byte_total;
    logic [31:0] word_queue [$];
    logic [2:0]  index_queue [$];
    logic        last_queue [$];
    int          error_count;

    function new();
        restart();
        error_count = 0;
    endfunction

    function void restart();
        for (int k = 0; k < 8; k++)
            hash_acc[k] = sha256_pkg::INITIAL_HASH[k];
        fill_count = 0;
        byte_total = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 compression rounds over the current block.
    function void compress();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wv, s0, s1, t1, t2;
        for (int r = 0; r < 16; r++)
            w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2],
                    block_bytes[4*r+3]};
        for (int k = 0; k < 8; k++)
            v[k] = hash_acc[k];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                wv = w[r];
            else
            begin
                s0 = ror(w[(r-15)&15], 7) ^ ror(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
                s1 = ror(w[(r-2)&15], 17) ^ ror(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                wv = w[r&15] + s0 + w[(r-7)&15] + s1;
                w[r&15] = wv;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_KEYS[r] + wv;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++)
            hash_acc[k] += v[k];
    endfunction

    // Note an accepted item; an end mark queues eight digest words.
    function void note_item(logic [7:0] data, logic present, logic close);
        int unsigned pos;
        logic [63:0] bit_len;
        if (present)
        begin
            block_bytes[fill_count] = data;
            byte_total++;
            fill_count++;
            if (fill_count == 64)
            begin
                compress();
                fill_count = 0;
            end
        end
        if (!close)
            return;
        pos = fill_count;
        block_bytes[pos++] = sha256_pkg::PAD_BYTE;
        if (pos > 56)
        begin
            while (pos < 64)
                block_bytes[pos++] = 8'h00;
            compress();
            pos = 0;
        end
        while (pos < 56)
            block_bytes[pos++] = 8'h00;
        bit_len = {byte_total, 3'b000};
        for (int k = 0; k < 8; k++)
            block_bytes[63-k] = bit_len[8*k +: 8];
        compress();
        for (int k = 0; k < 8; k++)
        begin
            word_queue.push_back(hash_acc[k]);
            index_queue.push_back(k[2:0]);
            last_queue.push_back(k == 7);
        end
        restart();
    endfunction

    // Compare one accepted digest word with the oldest prediction.
    function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
        if (word_queue.size() == 0)
        begin
            $display("%0t: unexpected digest word %h", $time, word);
            error_count++;
            return;
        end
        if (word !== word_queue[0] || idx !== index_queue[0] || last !== last_queue[0])
        begin
            $display("%0t: expected word %h num %0d last %b, got %h num %0d last %b",
                     $time, word_queue[0], index_queue[0], last_queue[0], word, idx, last);
            error_count++;
        end
        void'(word_queue.pop_front());
        void'(index_queue.pop_front());
        void'(last_queue.pop_front());
    endfunction
endclass

module sha256_message_digest_tb;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  message_byte;
    logic        byte_present;
    logic        message_end;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_last;
    logic        quiet_phase;

    digest_scoreboard board;

    sha256_message_digest i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_byte (message_byte),
        .byte_present (byte_present),
        .message_end  (message_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_word  (digest_word),
        .word_number  (word_number),
        .digest_last  (digest_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one item and hold it until accepted; maybe idle first.
    task automatic send_item(logic [7:0] data, logic present, logic close);
        int gap;
        if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        message_byte <= data;
        byte_present <= present;
        message_end  <= close;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_item(data, present, close);
        @(negedge clk);
    endtask

    // Send a message of random bytes, with idle items sprinkled in.
    task automatic send_message(int unsigned len, logic end_with_byte);
        for (int unsigned k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, end_with_byte && k == len - 1);
        end
        if (!end_with_byte || len == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Sample digest words and stall in random bursts.
    initial
    begin
        int burst;
        burst = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_word(digest_word, word_number, digest_last);
            @(negedge clk);
            if (burst > 0)
                burst--;
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
                burst = $urandom_range(1, 6);
            out_stall <= (burst > 0);
        end
    end

    // Limit on run time.
    initial
    begin
        #20ms;
        $display("sha256_message_digest: mismatch");
        $finish;
    end

    initial
    begin
        board = new();
        quiet_phase  = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        message_byte = 8'h00;
        byte_present = 1'b0;
        message_end  = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty message, idle item, extremes.
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b1);

        // Padding that spills into an extra block, end mark on its own item.
        send_message(56, 1'b0);

        // Full block closed by its last byte, with no idling at the end.
        quiet_phase = 1'b1;
        send_message(64, 1'b1);
        in_valid <= 1'b0;

        while (board.word_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.error_count == 0 && board.word_queue.size() == 0)
            $display("sha256_message_digest: match");
        else
            $display("sha256_message_digest: mismatch");
        $finish;
    end
endmodule
